// ----- rtl/btpc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// No dependencies.
package btpc_pkg;

  localparam int QW = 32;

  localparam logic [2:0] REG_T1   = 3'd0;
  localparam logic [2:0] REG_T2   = 3'd1;
  localparam logic [2:0] REG_T3   = 3'd2;
  localparam logic [2:0] REG_P1   = 3'd3;
  localparam logic [2:0] REG_P234 = 3'd4;
  localparam logic [2:0] REG_P567 = 3'd5;
  localparam logic [2:0] REG_P89  = 3'd6;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [47:0] p234;
    logic [47:0] p567;
    logic [31:0] p89;
  } cal_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic        pressure_invalid;
  } out_word_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    sra = 32'($signed(x) >>> n);
  endfunction

endpackage

// ----- rtl/btpc_if.sv -----
// Valid/ready channel carrying one word.
// Depends on btpc_pkg only through the type parameter.
interface btpc_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/baro_temp_pressure_compensation.sv -----
// Top level: calibration registers, compensation pipeline, divider, output skid.
// Depends on btpc_pkg, btpc_if, btpc_cfg, btpc_div.
//
//  channel  dir  payload
//  in_ch    in   raw_pressure, raw_temperature
//  out_ch   out  temperature_centi, pressure_pa, pressure_invalid
//  apb      in   seven calibration registers at 8*i
//
// One word per cycle; the path runs through 8 front stages + 32 divider stages
// + 3 back stages + the output register. The whole pipe advances while the
// skid register is empty; a held output fills the skid, then stalls the input.
// Reset empties all valid bits and clears calibration to zero.
module baro_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  btpc_if.sink        in_ch,
  btpc_if.source      out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import btpc_pkg::*;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] p;
    logic        inv;
  } tag_t;

  cal_t cal;
  btpc_cfg u_cfg (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cal);

  logic en;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  always_comb begin
    t1 = {16'd0, cal.t1};
    t2 = sx16(cal.t2);
    t3 = sx16(cal.t3);
    p1 = {16'd0, cal.p1};
    p2 = sx16(cal.p234[15:0]);
    p3 = sx16(cal.p234[31:16]);
    p4 = sx16(cal.p234[47:32]);
    p5 = sx16(cal.p567[15:0]);
    p6 = sx16(cal.p567[31:16]);
    p7 = sx16(cal.p567[47:32]);
    p8 = sx16(cal.p89[15:0]);
    p9 = sx16(cal.p89[31:16]);
  end

  // front stages
  logic [8:1] v;
  logic [19:0] adp [1:7];
  logic [31:0] s1_x, s1_d;
  logic [31:0] s2_a, s2_dd;
  logic [31:0] s3_fine;
  logic [31:0] s4_temp, s4_a;
  logic [31:0] s5_temp, s5_sq, s5_ap5, s5_p2a;
  logic [31:0] s6_temp, s6_b, s6_x3;
  logic [31:0] s7_temp, s7_b, s7_x4;
  logic [31:0] s8_temp, s8_num, s8_den;
  logic [31:0] s3_b_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:1], in_ch.valid};
    end
    if (en) begin
      adp[1] <= in_ch.data.raw_pressure;
      for (int i = 2; i <= 7; i++) adp[i] <= adp[i-1];
      s1_x <= {15'd0, in_ch.data.raw_temperature[19:3]} - (t1 << 1);
      s1_d <= {16'd0, in_ch.data.raw_temperature[19:4]} - t1;
      s2_a  <= sra(s1_x * t2, 11);
      s2_dd <= s1_d * s1_d;
      s3_b_mul <= sra(s2_dd, 12) * t3;
      s3_fine  <= s2_a;
      s4_temp <= sra(s3_fine + sra(s3_b_mul, 14), 0);
      s4_a    <= sra(s3_fine + sra(s3_b_mul, 14), 1) - 32'd64000;
      s5_temp <= sra(s4_temp * 32'd5 + 32'd128, 8);
      s5_sq   <= sra(s4_a, 2) * sra(s4_a, 2);
      s5_ap5  <= s4_a * p5;
      s5_p2a  <= p2 * s4_a;
      s6_temp <= s5_temp;
      s6_b    <= sra(s5_sq, 11) * p6 + (s5_ap5 << 1);
      s6_x3   <= sra(p3 * sra(s5_sq, 13), 3) + sra(s5_p2a, 1);
      s7_temp <= s6_temp;
      s7_b    <= sra(s6_b, 2) + (p4 << 16);
      s7_x4   <= (32'd32768 + sra(s6_x3, 18)) * p1;
      s8_temp <= s7_temp;
      s8_num  <= ((32'd1048576 - {12'd0, adp[7]}) - sra(s7_b, 12)) * 32'd3125;
      s8_den  <= sra(s7_x4, 15);
    end
  end

  // divider
  logic        big, dv_v;
  logic [31:0] dnum, dquo;
  tag_t        dtag_in, dtag;
  assign big  = s8_num[31];
  assign dnum = big ? s8_num : (s8_num << 1);
  always_comb begin
    dtag_in.temp = s8_temp;
    dtag_in.p    = {31'd0, big};
    dtag_in.inv  = (s8_den == '0);
  end
  btpc_div #(.tag_t(tag_t)) u_div (.clk, .rst, .en, .in_valid(v[8]),
    .in_num(dnum), .in_den(s8_den), .in_tag(dtag_in), .out_valid(dv_v),
    .out_quo(dquo), .out_tag(dtag));

  // back stages
  logic [3:1]  bv;
  tag_t        b1, b2, b3;
  logic [31:0] b0_p, b1_sq;
  logic [31:0] b2_a, b2_b;
  assign b0_p = dtag.inv ? '0 : (dtag.p[0] ? (dquo << 1) : dquo);
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[2:1], dv_v};
    end
    if (en) begin
      b1.temp <= dtag.temp;
      b1.inv  <= dtag.inv;
      b1.p    <= b0_p;
      b1_sq   <= (b0_p >> 3) * (b0_p >> 3);
      b2      <= b1;
      b2_a    <= p9 * (b1_sq >> 13);
      b2_b    <= (b1.p >> 2) * p8;
      b3.temp <= b2.temp;
      b3.inv  <= b2.inv;
      b3.p    <= b2.inv ? '0 :
                 b2.p + sra(sra(b2_a, 12) + sra(b2_b, 13) + p7, 4);
    end
  end

  // output register with skid
  logic      o_v, s_v;
  out_word_t o_d, s_d, w;
  assign w  = '{temperature_centi: b3.temp, pressure_pa: b3.p,
                pressure_invalid: b3.inv};
  assign en = !s_v;
  assign in_ch.ready = en;
  assign out_ch.valid = o_v;
  assign out_ch.data  = o_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else begin
      if (!o_v || out_ch.ready) begin
        o_v <= s_v || (en && bv[3]);
        s_v <= 1'b0;
      end else if (en && bv[3]) begin
        s_v <= 1'b1;
      end
    end
    if (!o_v || out_ch.ready) begin
      o_d <= s_v ? s_d : w;
    end else if (en && bv[3]) begin
      s_d <= w;
    end
  end

`ifndef SYNTHESIS
  a_skid_only_when_held: assert property (@(posedge clk) disable iff (rst)
    s_v |-> o_v) else $error("skid full with empty output");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (o_v && !out_ch.ready) |=> (o_v && $stable(o_d))) else $error("output lost");
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && o_d.pressure_invalid) |-> (o_d.pressure_pa == '0))
    else $error("invalid pressure not zero");
`endif
endmodule

// ----- rtl/btpc_div.sv -----
// Pipelined unsigned 32/32 divider, one quotient bit per stage.
// Depends on btpc_pkg.
module btpc_div #(
  parameter type tag_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_num,
  input  logic [31:0] in_den,
  input  tag_t        in_tag,
  output logic        out_valid,
  output logic [31:0] out_quo,
  output tag_t        out_tag
);
  import btpc_pkg::*;

  logic [31:0] num [0:QW];
  logic [31:0] den [0:QW];
  logic [31:0] rem [0:QW];
  tag_t        tag [0:QW];
  logic        vld [0:QW];

  assign num[0] = in_num;
  assign den[0] = in_den;
  assign rem[0] = '0;
  assign tag[0] = in_tag;
  assign vld[0] = in_valid;

  for (genvar g = 0; g < QW; g++) begin : g_st
    logic [32:0] trial;
    logic [32:0] diff;
    always_comb begin
      trial = {rem[g], num[g][31]};
      diff  = trial - {1'b0, den[g]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        num[g+1] <= {num[g][30:0], ~diff[32]};
        rem[g+1] <= diff[32] ? trial[31:0] : diff[31:0];
        den[g+1] <= den[g];
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = num[QW];
  assign out_tag   = tag[QW];
endmodule

// ----- rtl/btpc_cfg.sv -----
// APB-style calibration register file.
// Depends on btpc_pkg.
module btpc_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  output btpc_pkg::cal_t       cal
);
  import btpc_pkg::*;

  logic [2:0] idx;
  logic       wr;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr) begin
      case (idx)
        REG_T1:   cal.t1 <= pwdata[15:0];
        REG_T2:   cal.t2 <= pwdata[15:0];
        REG_T3:   cal.t3 <= pwdata[15:0];
        REG_P1:   cal.p1 <= pwdata[15:0];
        REG_P234: cal.p234 <= pwdata[47:0];
        REG_P567: cal.p567 <= pwdata[47:0];
        REG_P89:  cal.p89 <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_T1:   prdata = {48'd0, cal.t1};
      REG_T2:   prdata = {48'd0, cal.t2};
      REG_T3:   prdata = {48'd0, cal.t3};
      REG_P1:   prdata = {48'd0, cal.p1};
      REG_P234: prdata = {16'd0, cal.p234};
      REG_P567: prdata = {16'd0, cal.p567};
      REG_P89:  prdata = {32'd0, cal.p89};
      default:  prdata = '0;
    endcase
  end
endmodule
